// File: src/spring_force_pair_macros.svh
// Assertion macros for the spring force pipeline.
// Expects clk_i and rst_ni in the including module; no other dependencies.
`ifndef SPRING_FORCE_PAIR_MACROS_SVH
`define SPRING_FORCE_PAIR_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock once reset is released
`define SPF_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("spring_force_pair: assertion failed");
// condition must never be seen
`define SPF_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("spring_force_pair: forbidden condition seen");
`else
`define SPF_ASSERT(name, prop)
`define SPF_NEVER(name, cond)
`endif
`endif

// File: src/spf_pkg.sv
// Shared widths, latencies and register indexes for the spring force pipeline.
// No dependencies.
package spf_pkg;

  localparam int unsigned POS_W     = 32;
  localparam int unsigned MASS_W    = 32;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned REG_IDX_W = 3;

  // position difference and its magnitude
  localparam int unsigned DIFF_W = POS_W + 1;
  // squared distance, root
  localparam int unsigned SQ_W   = 2 * DIFF_W;
  localparam int unsigned ROOT_W = DIFF_W;
  // k*|e|, partial products, numerators, denominators
  localparam int unsigned KE_W   = CFG_W + ROOT_W;
  localparam int unsigned PP_W   = 2 * DIFF_W;
  localparam int unsigned NUM_W  = KE_W + DIFF_W;
  localparam int unsigned DEN_W  = ROOT_W + MASS_W;
  // quotient bits below the saturation point
  localparam int unsigned QUO_W  = POS_W - 1;

  localparam int unsigned SQRT_LAT = ROOT_W;
  localparam int unsigned DIV_LAT  = QUO_W + 1;

  localparam logic [REG_IDX_W-1:0] REG_STIFFNESS = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_REST_LEN  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CONNECTED = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_IDX = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_IDX = 3'd4;

endpackage

// File: src/spf_sqrt.sv
// Pipelined integer square root, one result bit per stage (floor(sqrt(x))).
// Depends on spf_pkg for widths and latency.
module spf_sqrt import spf_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SQ_W-1:0]   x_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [ROOT_W-1:0] root_q [SQRT_LAT];
  logic [SQ_W-1:0]   rem_q  [SQRT_LAT-1];

  for (genvar gi = 0; gi < SQRT_LAT; gi++) begin : g_step
    localparam int unsigned BitPos = ROOT_W - 1 - gi;
    logic [SQ_W-1:0]   rem_in;
    logic [ROOT_W-1:0] r_in;
    logic [SQ_W+1:0]   trial;
    logic              take;

    if (gi == 0) begin : g_first
      assign rem_in = x_i;
      assign r_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[gi-1];
      assign r_in   = root_q[gi-1];
    end

    // (2r + 2^b) * 2^b against the remainder x - r^2
    assign trial = ((SQ_W+2)'(r_in) << (BitPos + 1)) | ((SQ_W+2)'(1) << (2 * BitPos));
    assign take  = ({2'b00, rem_in} >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[gi] <= take ? (r_in | (ROOT_W'(1) << BitPos)) : r_in;
      end
    end

    if (gi < SQRT_LAT - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[gi] <= take ? (rem_in - trial[SQ_W-1:0]) : rem_in;
        end
      end
    end
  end

  assign root_o = root_q[SQRT_LAT-1];

endmodule

// File: src/spf_div.sv
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
// Depends on spf_pkg for widths and latency.
module spf_div import spf_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             sat_o
);

  logic [DEN_W-1:0] rem_q [DIV_LAT];
  logic [DEN_W-1:0] den_q [DIV_LAT];
  logic [QUO_W-1:0] low_q [DIV_LAT];
  logic [QUO_W-1:0] quo_q [DIV_LAT];
  logic             sat_q [DIV_LAT];

  // quotient of 2^QUO_W or more saturates every output format
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q[0] <= (num_i[NUM_W-1:QUO_W] >= (NUM_W-QUO_W)'(den_i));
      rem_q[0] <= num_i[QUO_W+DEN_W-1:QUO_W];
      den_q[0] <= den_i;
      low_q[0] <= num_i[QUO_W-1:0];
      quo_q[0] <= '0;
    end
  end

  for (genvar gi = 1; gi < DIV_LAT; gi++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           take;

    assign trial = {rem_q[gi-1], low_q[gi-1][QUO_W-1]};
    assign diff  = trial - {1'b0, den_q[gi-1]};
    assign take  = (trial >= {1'b0, den_q[gi-1]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[gi] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        den_q[gi] <= den_q[gi-1];
        low_q[gi] <= {low_q[gi-1][QUO_W-2:0], 1'b0};
        quo_q[gi] <= {quo_q[gi-1][QUO_W-2:0], take};
        sat_q[gi] <= sat_q[gi-1];
      end
    end
  end

  assign quo_o = quo_q[DIV_LAT-1];
  assign sat_o = sat_q[DIV_LAT-1];

endmodule

// File: src/spring_force_pair.sv
// Throughput: one spring per cycle; the pipeline (square root and four dividers,
// one bit per stage) advances as a whole and stops only while a result is held.
// Reset: all five configuration registers clear to zero and every stage valid
// clears; there is no clearing pass, the block is ready right after reset.
`include "spring_force_pair_macros.svh"
module spring_force_pair import spf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [REG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [POS_W-1:0]  first_pos_x_i,
  input  logic signed [POS_W-1:0]  first_pos_y_i,
  input  logic signed [POS_W-1:0]  second_pos_x_i,
  input  logic signed [POS_W-1:0]  second_pos_y_i,
  input  logic [MASS_W-1:0]        first_mass_i,
  input  logic [MASS_W-1:0]        second_mass_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [POS_W-1:0]  first_accel_x_o,
  output logic signed [POS_W-1:0]  first_accel_y_o,
  output logic signed [POS_W-1:0]  second_accel_x_o,
  output logic signed [POS_W-1:0]  second_accel_y_o,
  output logic [CFG_W-1:0]         spring_energy_o,
  output logic [IDX_W-1:0]         first_target_o,
  output logic [IDX_W-1:0]         second_target_o,
  output logic                     mass_fault_o
);

  localparam int unsigned ENERGY_SHIFT = 33;
  localparam logic [POS_W-1:0] SAT_POS = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] SAT_NEG = {1'b1, {(POS_W-1){1'b0}}};

  typedef struct packed {
    logic              vld;
    logic [DIFF_W-1:0] ax;
    logic [DIFF_W-1:0] ay;
    logic              xneg;
    logic              yneg;
    logic [MASS_W-1:0] m1;
    logic [MASS_W-1:0] m2;
  } geo_t;

  typedef struct packed {
    logic vld;
    logic n1x;
    logic n1y;
    logic n2x;
    logic n2y;
    logic m1z;
    logic m2z;
  } flag_t;

  typedef struct packed {
    flag_t             fl;
    logic [ROOT_W-1:0] emag;
    logic [ROOT_W-1:0] span;
    logic [DIFF_W-1:0] ax;
    logic [DIFF_W-1:0] ay;
    logic [MASS_W-1:0] m1;
    logic [MASS_W-1:0] m2;
  } p1_t;

  typedef struct packed {
    flag_t             fl;
    logic [ROOT_W-1:0] emag;
    logic [DIFF_W-1:0] ax;
    logic [DIFF_W-1:0] ay;
    logic [KE_W-1:0]   ke;
    logic [DEN_W-1:0]  den1;
    logic [DEN_W-1:0]  den2;
  } p2_t;

  typedef struct packed {
    flag_t            fl;
    logic [DEN_W-1:0] den1;
    logic [DEN_W-1:0] den2;
    logic [PP_W-1:0]  pe_lo;
    logic [PP_W-1:0]  pe_hi;
    logic [PP_W-1:0]  px_lo;
    logic [PP_W-1:0]  px_hi;
    logic [PP_W-1:0]  py_lo;
    logic [PP_W-1:0]  py_hi;
  } p3_t;

  typedef struct packed {
    flag_t            fl;
    logic [DEN_W-1:0] den1;
    logic [DEN_W-1:0] den2;
    logic [NUM_W-1:0] en;
    logic [NUM_W-1:0] numx;
    logic [NUM_W-1:0] numy;
  } p4_t;

  typedef struct packed {
    flag_t            fl;
    logic [CFG_W-1:0] energy;
  } tail_t;

  // final output format: saturated quotient with sign applied
  function automatic logic [POS_W-1:0] fmt_accel(input logic sat, input logic neg,
                                                 input logic [QUO_W-1:0] quo);
    logic [POS_W-1:0] mag;
    mag = {1'b0, quo};
    if (sat) begin
      fmt_accel = neg ? SAT_NEG : SAT_POS;
    end else begin
      fmt_accel = neg ? (POS_W'(0) - mag) : mag;
    end
  endfunction

  // configuration registers
  logic [CFG_W-1:0] stiff_q;
  logic [CFG_W-1:0] rest_q;
  logic             conn_q;
  logic [IDX_W-1:0] first_idx_q;
  logic [IDX_W-1:0] second_idx_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q      <= '0;
      rest_q       <= '0;
      conn_q       <= 1'b0;
      first_idx_q  <= '0;
      second_idx_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_STIFFNESS:  stiff_q      <= cfg_data_i;
        REG_REST_LEN:   rest_q       <= cfg_data_i;
        REG_CONNECTED:  conn_q       <= cfg_data_i[0];
        REG_FIRST_IDX:  first_idx_q  <= cfg_data_i[IDX_W-1:0];
        REG_SECOND_IDX: second_idx_q <= cfg_data_i[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless a finished beat is held at the output
  logic out_valid_q;
  logic adv;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // stage 0: position differences
  logic                     s0_vld_q;
  logic signed [DIFF_W-1:0] s0_dx_q;
  logic signed [DIFF_W-1:0] s0_dy_q;
  logic [MASS_W-1:0]        s0_m1_q;
  logic [MASS_W-1:0]        s0_m2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_dx_q <= DIFF_W'(second_pos_x_i) - DIFF_W'(first_pos_x_i);
      s0_dy_q <= DIFF_W'(second_pos_y_i) - DIFF_W'(first_pos_y_i);
      s0_m1_q <= first_mass_i;
      s0_m2_q <= second_mass_i;
    end
  end

  // stage 1: magnitudes; stage 2: squares; stage 3: squared distance
  geo_t            s1_q, s2_q, s3_q;
  logic [PP_W-1:0] s2_ax2_q, s2_ay2_q;
  logic [SQ_W-1:0] s3_d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else if (adv) begin
      s1_q.vld  <= s0_vld_q;
      s1_q.ax   <= s0_dx_q[DIFF_W-1] ? DIFF_W'(-s0_dx_q) : DIFF_W'(s0_dx_q);
      s1_q.ay   <= s0_dy_q[DIFF_W-1] ? DIFF_W'(-s0_dy_q) : DIFF_W'(s0_dy_q);
      s1_q.xneg <= s0_dx_q[DIFF_W-1];
      s1_q.yneg <= s0_dy_q[DIFF_W-1];
      s1_q.m1   <= s0_m1_q;
      s1_q.m2   <= s0_m2_q;
      s2_q      <= s1_q;
      s3_q      <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_ax2_q <= PP_W'(s1_q.ax) * PP_W'(s1_q.ax);
      s2_ay2_q <= PP_W'(s1_q.ay) * PP_W'(s1_q.ay);
      s3_d2_q  <= s2_ax2_q + s2_ay2_q;
    end
  end

  // square root with the geometry riding alongside
  logic [ROOT_W-1:0] root;
  geo_t              sq_line_q [SQRT_LAT];

  spf_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .x_i    (s3_d2_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SQRT_LAT; i++) sq_line_q[i] <= '0;
    end else if (adv) begin
      sq_line_q[0] <= s3_q;
      for (int i = 1; i < SQRT_LAT; i++) sq_line_q[i] <= sq_line_q[i-1];
    end
  end

  // p1: stretch and the coincident-particle fallback to +x
  geo_t                   gq;
  logic signed [ROOT_W:0] stretch;
  logic                   coincide;
  logic                   xneg_eff, yneg_eff, eneg;

  assign gq       = sq_line_q[SQRT_LAT-1];
  assign stretch  = signed'({1'b0, root}) - signed'({2'b00, rest_q});
  assign coincide = (root == '0);
  assign eneg     = stretch[ROOT_W];
  assign xneg_eff = gq.xneg && !coincide;
  assign yneg_eff = gq.yneg && !coincide;

  p1_t p1_q;
  p2_t p2_q;
  p3_t p3_q;
  p4_t p4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= '0;
      p2_q <= '0;
      p3_q <= '0;
      p4_q <= '0;
    end else if (adv) begin
      p1_q.fl.vld <= gq.vld;
      p1_q.fl.n1x <= eneg ^ xneg_eff;
      p1_q.fl.n1y <= eneg ^ yneg_eff;
      p1_q.fl.n2x <= !(eneg ^ xneg_eff);
      p1_q.fl.n2y <= !(eneg ^ yneg_eff);
      p1_q.fl.m1z <= (gq.m1 == '0);
      p1_q.fl.m2z <= (gq.m2 == '0);
      p1_q.emag   <= eneg ? ROOT_W'(-stretch) : ROOT_W'(stretch);
      p1_q.span   <= coincide ? ROOT_W'(1) : root;
      p1_q.ax     <= coincide ? DIFF_W'(1) : gq.ax;
      p1_q.ay     <= coincide ? '0 : gq.ay;
      p1_q.m1     <= gq.m1;
      p1_q.m2     <= gq.m2;

      // p2: k*|e| and the two denominators
      p2_q.fl   <= p1_q.fl;
      p2_q.emag <= p1_q.emag;
      p2_q.ax   <= p1_q.ax;
      p2_q.ay   <= p1_q.ay;
      p2_q.ke   <= KE_W'(stiff_q) * KE_W'(p1_q.emag);
      p2_q.den1 <= DEN_W'(p1_q.span) * DEN_W'(p1_q.m1);
      p2_q.den2 <= DEN_W'(p1_q.span) * DEN_W'(p1_q.m2);

      // p3: split k*|e| into low and high halves, partial products
      p3_q.fl    <= p2_q.fl;
      p3_q.den1  <= p2_q.den1;
      p3_q.den2  <= p2_q.den2;
      p3_q.pe_lo <= PP_W'(p2_q.ke[CFG_W-1:0]) * PP_W'(p2_q.emag);
      p3_q.pe_hi <= PP_W'(p2_q.ke[KE_W-1:CFG_W]) * PP_W'(p2_q.emag);
      p3_q.px_lo <= PP_W'(p2_q.ke[CFG_W-1:0]) * PP_W'(p2_q.ax);
      p3_q.px_hi <= PP_W'(p2_q.ke[KE_W-1:CFG_W]) * PP_W'(p2_q.ax);
      p3_q.py_lo <= PP_W'(p2_q.ke[CFG_W-1:0]) * PP_W'(p2_q.ay);
      p3_q.py_hi <= PP_W'(p2_q.ke[KE_W-1:CFG_W]) * PP_W'(p2_q.ay);

      // p4: recombine into energy and numerators
      p4_q.fl   <= p3_q.fl;
      p4_q.den1 <= p3_q.den1;
      p4_q.den2 <= p3_q.den2;
      p4_q.en   <= NUM_W'(p3_q.pe_lo) + (NUM_W'(p3_q.pe_hi) << CFG_W);
      p4_q.numx <= NUM_W'(p3_q.px_lo) + (NUM_W'(p3_q.px_hi) << CFG_W);
      p4_q.numy <= NUM_W'(p3_q.py_lo) + (NUM_W'(p3_q.py_hi) << CFG_W);
    end
  end

  // energy = k*e^2 / 2^33, saturated
  logic [CFG_W-1:0] energy_sat;
  assign energy_sat = (|p4_q.en[NUM_W-1:ENERGY_SHIFT+CFG_W]) ? '1 :
                      p4_q.en[ENERGY_SHIFT+CFG_W-1:ENERGY_SHIFT];

  // four dividers: x and y for each particle
  logic [QUO_W-1:0] q1x, q1y, q2x, q2y;
  logic             s1x, s1y, s2x, s2y;

  spf_div u_div_1x (.clk_i(clk_i), .en_i(adv), .num_i(p4_q.numx), .den_i(p4_q.den1),
                    .quo_o(q1x), .sat_o(s1x));
  spf_div u_div_1y (.clk_i(clk_i), .en_i(adv), .num_i(p4_q.numy), .den_i(p4_q.den1),
                    .quo_o(q1y), .sat_o(s1y));
  spf_div u_div_2x (.clk_i(clk_i), .en_i(adv), .num_i(p4_q.numx), .den_i(p4_q.den2),
                    .quo_o(q2x), .sat_o(s2x));
  spf_div u_div_2y (.clk_i(clk_i), .en_i(adv), .num_i(p4_q.numy), .den_i(p4_q.den2),
                    .quo_o(q2y), .sat_o(s2y));

  tail_t dv_line_q [DIV_LAT];
  tail_t dv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) dv_line_q[i] <= '0;
    end else if (adv) begin
      dv_line_q[0].fl     <= p4_q.fl;
      dv_line_q[0].energy <= energy_sat;
      for (int i = 1; i < DIV_LAT; i++) dv_line_q[i] <= dv_line_q[i-1];
    end
  end

  assign dv = dv_line_q[DIV_LAT-1];

  // output register: masking for unconnected springs and zero masses
  logic [POS_W-1:0] acc1x_q, acc1y_q, acc2x_q, acc2y_q;
  logic [CFG_W-1:0] energy_q;
  logic [IDX_W-1:0] tgt1_q, tgt2_q;
  logic             fault_q;
  logic             use1, use2;

  assign use1 = conn_q && !dv.fl.m1z;
  assign use2 = conn_q && !dv.fl.m2z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv.fl.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      acc1x_q  <= use1 ? fmt_accel(s1x, dv.fl.n1x, q1x) : '0;
      acc1y_q  <= use1 ? fmt_accel(s1y, dv.fl.n1y, q1y) : '0;
      acc2x_q  <= use2 ? fmt_accel(s2x, dv.fl.n2x, q2x) : '0;
      acc2y_q  <= use2 ? fmt_accel(s2y, dv.fl.n2y, q2y) : '0;
      energy_q <= conn_q ? dv.energy : '0;
      fault_q  <= conn_q && (dv.fl.m1z || dv.fl.m2z);
      tgt1_q   <= first_idx_q;
      tgt2_q   <= second_idx_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign first_accel_x_o  = signed'(acc1x_q);
  assign first_accel_y_o  = signed'(acc1y_q);
  assign second_accel_x_o = signed'(acc2x_q);
  assign second_accel_y_o = signed'(acc2y_q);
  assign spring_energy_o  = energy_q;
  assign first_target_o   = tgt1_q;
  assign second_target_o  = tgt2_q;
  assign mass_fault_o     = fault_q;

  // a fault always zeroes at least one particle
  `SPF_ASSERT(a_fault_zeroes_side, out_valid_q && fault_q |-> (acc1x_q == '0 && acc1y_q == '0) || (acc2x_q == '0 && acc2y_q == '0))
  // the two particles are pushed in opposite directions
  `SPF_NEVER(a_push_pull, out_valid_q && ((acc1x_q[POS_W-1] && acc2x_q[POS_W-1]) || (acc1y_q[POS_W-1] && acc2y_q[POS_W-1])))
  // divider overflow lands on a saturation code
  `SPF_ASSERT(a_overflow_saturates, adv && dv.fl.vld && s1x && use1 |=> acc1x_q == SAT_POS || acc1x_q == SAT_NEG)

endmodule
